// File: sv/prs_pkg.sv
// Shared types, constants and a helper function of the piece request scheduler.
package prs_pkg;

  localparam int MAX_PIECE_COUNT_DEF = 64;
  localparam int MAX_PEER_COUNT_DEF  = 16;

  localparam int PEER_W      = 4;
  localparam int PIECE_W     = 6;
  localparam int PEERS_W     = 5;
  localparam int PIECES_W    = 7;
  localparam int OPCODE_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int ROW_LIMIT   = 16;
  localparam int CHUNK_W     = 8;
  localparam int CHUNK_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MY_PEER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIECE_TOTAL = 2'd2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_HAVE  = 2'd0,
    OP_REPLY = 2'd1,
    OP_SCHED = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIND,
    ST_SRC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [PEER_W-1:0]   my_peer_index;
    logic [PEERS_W-1:0]  peer_count;
    logic [PIECES_W-1:0] piece_total;
  } cfg_t;

  typedef struct packed {
    logic               row_set;
    logic               row_clr;
    logic               held_set;
    logic [PEER_W-1:0]  row;
    logic [PIECE_W-1:0] piece;
  } store_cmd_t;

  function automatic logic [CHUNK_IDX_W-1:0] low_index8(input logic [CHUNK_W-1:0] v);
    logic [CHUNK_IDX_W-1:0] idx;
    idx = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = CHUNK_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: sv/prs_if.sv
// Channel interfaces for requests in, results out and configuration writes.
interface prs_in_if;
  import prs_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [PEER_W-1:0]   peer_index;
  logic [PIECE_W-1:0]  piece_index;
  logic                reply_ok;
  modport source (output valid, opcode, peer_index, piece_index, reply_ok, input ready);
  modport sink (input valid, opcode, peer_index, piece_index, reply_ok, output ready);
endinterface

interface prs_out_if;
  import prs_pkg::*;
  logic               valid;
  logic               ready;
  logic               request_valid;
  logic [PIECE_W-1:0] wanted_piece;
  logic [PEER_W-1:0]  request_peer;
  logic               announce_valid;
  logic [PIECE_W-1:0] announce_piece;
  logic               pending;
  logic               all_done;
  modport source (output valid, request_valid, wanted_piece, request_peer, announce_valid,
                  announce_piece, pending, all_done, input ready);
  modport sink (input valid, request_valid, wanted_piece, request_peer, announce_valid,
                announce_piece, pending, all_done, output ready);
endinterface

interface prs_cfg_if;
  import prs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: sv/piece_request_scheduler.sv
// Top level of the piece request scheduler: configuration registers, sequencer and bitmap store.
//
//   Channel  Port    Role    Payload
//   input    item    sink    opcode, peer_index, piece_index, reply_ok
//   output   result  source  request_valid, wanted_piece, request_peer, announce_valid/piece,
//                            pending, all_done
//   config   setup   sink    reg_index, wdata
//
// A have announcement, a reply or a refused schedule goes through the execute and done states
// before its result is registered, and the next request can be taken while that result is valid.
// A schedule reads the peer rows to gather candidates, searches the candidates in chunks of
// eight pieces, and reads rows again from peer 1 to pick the source (not with a single peer).
// Only one request is in the block at a time. Reset clears every bitmap at once; a stalled
// result register holds its request and keeps the next one waiting in its last step.
module piece_request_scheduler #(
  parameter int MAX_PIECE_COUNT = prs_pkg::MAX_PIECE_COUNT_DEF,
  parameter int MAX_PEER_COUNT  = prs_pkg::MAX_PEER_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  prs_in_if.sink    item,
  prs_out_if.source result,
  prs_cfg_if.sink   setup
);
  import prs_pkg::*;

  localparam int NUM_ROWS = (MAX_PEER_COUNT < ROW_LIMIT) ? MAX_PEER_COUNT : ROW_LIMIT;
  localparam int ROW_W    = $clog2(NUM_ROWS);

  cfg_t                       cfg;
  store_cmd_t                 cmd;
  logic [ROW_W-1:0]           rd_row;
  logic [MAX_PIECE_COUNT-1:0] rd_data;
  logic [MAX_PIECE_COUNT-1:0] held;

  assign setup.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.my_peer_index <= PEER_W'(1);
      cfg.peer_count    <= PEERS_W'(2);
      cfg.piece_total   <= PIECES_W'(64);
    end else if (setup.valid) begin
      unique case (setup.reg_index)
        CFG_MY_PEER:     cfg.my_peer_index <= setup.wdata[PEER_W-1:0];
        CFG_PEER_COUNT:  cfg.peer_count    <= setup.wdata[PEERS_W-1:0];
        CFG_PIECE_TOTAL: cfg.piece_total   <= setup.wdata[PIECES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  prs_ctrl #(
    .MAX_PIECE_COUNT(MAX_PIECE_COUNT),
    .MAX_PEER_COUNT (MAX_PEER_COUNT)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .rd_row (rd_row),
    .rd_data(rd_data),
    .held   (held)
  );

  prs_store #(
    .MAX_PIECE_COUNT(MAX_PIECE_COUNT),
    .MAX_PEER_COUNT (MAX_PEER_COUNT)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .rd_row (rd_row),
    .rd_data(rd_data),
    .held   (held)
  );

endmodule

// File: sv/prs_store.sv
// Peer availability rows, held piece bitmap: a row and a held write, a row read per cycle.
module prs_store #(
  parameter int MAX_PIECE_COUNT = prs_pkg::MAX_PIECE_COUNT_DEF,
  parameter int MAX_PEER_COUNT  = prs_pkg::MAX_PEER_COUNT_DEF,
  localparam int NUM_ROWS    = (MAX_PEER_COUNT < prs_pkg::ROW_LIMIT) ? MAX_PEER_COUNT
                                                                      : prs_pkg::ROW_LIMIT,
  localparam int ROW_W       = $clog2(NUM_ROWS),
  localparam int PIECE_IDX_W = $clog2(MAX_PIECE_COUNT)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  prs_pkg::store_cmd_t        cmd,
  input  logic [ROW_W-1:0]           rd_row,
  output logic [MAX_PIECE_COUNT-1:0] rd_data,
  output logic [MAX_PIECE_COUNT-1:0] held
);
  import prs_pkg::*;

  logic [MAX_PIECE_COUNT-1:0] rows [NUM_ROWS];
  logic [MAX_PIECE_COUNT-1:0] held_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows      <= '{default: '0};
      held_bits <= '0;
    end else begin
      if (cmd.row_set) begin
        rows[cmd.row[ROW_W-1:0]][cmd.piece[PIECE_IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.row_clr) begin
        rows[cmd.row[ROW_W-1:0]][cmd.piece[PIECE_IDX_W-1:0]] <= 1'b0;
      end
      if (cmd.held_set) begin
        held_bits[cmd.piece[PIECE_IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  assign rd_data = rows[rd_row];
  assign held    = held_bits;

endmodule

// File: sv/prs_ctrl.sv
// Sequencer that runs each request over the shared row read port and builds the result.
module prs_ctrl #(
  parameter int MAX_PIECE_COUNT = prs_pkg::MAX_PIECE_COUNT_DEF,
  parameter int MAX_PEER_COUNT  = prs_pkg::MAX_PEER_COUNT_DEF,
  localparam int NUM_ROWS    = (MAX_PEER_COUNT < prs_pkg::ROW_LIMIT) ? MAX_PEER_COUNT
                                                                      : prs_pkg::ROW_LIMIT,
  localparam int ROW_W       = $clog2(NUM_ROWS),
  localparam int PIECE_IDX_W = $clog2(MAX_PIECE_COUNT)
) (
  input  logic                       clk,
  input  logic                       rst,
  prs_in_if.sink                     item,
  prs_out_if.source                  result,
  input  prs_pkg::cfg_t              cfg,
  output prs_pkg::store_cmd_t        cmd,
  output logic [ROW_W-1:0]           rd_row,
  input  logic [MAX_PIECE_COUNT-1:0] rd_data,
  input  logic [MAX_PIECE_COUNT-1:0] held
);
  import prs_pkg::*;

  localparam int NUM_CHUNKS = (MAX_PIECE_COUNT + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W      = NUM_CHUNKS * CHUNK_W;

  state_t state, state_next;

  logic [OPCODE_W-1:0] op, op_next;
  logic [PEER_W-1:0]   pidx, pidx_next;
  logic [PIECE_W-1:0]  piece_in, piece_in_next;
  logic                ok, ok_next;

  logic               waiting_flag, waiting_flag_next;
  logic [PIECE_W-1:0] waiting_piece, waiting_piece_next;
  logic [PEER_W-1:0]  waiting_peer, waiting_peer_next;

  logic [PEER_W-1:0]          p, p_next;
  logic [MAX_PIECE_COUNT-1:0] acc, acc_next;
  logic [PAD_W-1:0]           cand, cand_next;
  logic [PIECE_W-1:0]         base, base_next;
  logic [PIECE_W-1:0]         sel_piece, sel_piece_next;

  logic               res_rq_valid, res_rq_valid_next;
  logic [PIECE_W-1:0] res_rq_piece, res_rq_piece_next;
  logic [PEER_W-1:0]  res_rq_peer, res_rq_peer_next;
  logic               res_an_valid, res_an_valid_next;
  logic [PIECE_W-1:0] res_an_piece, res_an_piece_next;

  logic               out_valid, out_valid_next;
  logic               out_rq_valid, out_rq_valid_next;
  logic [PIECE_W-1:0] out_rq_piece, out_rq_piece_next;
  logic [PEER_W-1:0]  out_rq_peer, out_rq_peer_next;
  logic               out_an_valid, out_an_valid_next;
  logic [PIECE_W-1:0] out_an_piece, out_an_piece_next;
  logic               out_pending, out_pending_next;
  logic               out_done, out_done_next;

  logic [PEERS_W-1:0]         npeers;
  logic [PIECES_W-1:0]        npieces;
  logic [MAX_PIECE_COUNT-1:0] piece_mask;
  logic                       last_peer;
  logic                       usable;
  logic [MAX_PIECE_COUNT-1:0] acc_now;
  logic [CHUNK_W-1:0]         low_chunk;
  logic [CHUNK_IDX_W-1:0]     enc;
  logic [PIECE_W-1:0]         found_piece;
  logic                       row_bit;
  logic                       all_done_now;

  assign npeers  = (cfg.peer_count < PEERS_W'(NUM_ROWS)) ? cfg.peer_count : PEERS_W'(NUM_ROWS);
  assign npieces = (cfg.piece_total < PIECES_W'(MAX_PIECE_COUNT)) ? cfg.piece_total
                                                                  : PIECES_W'(MAX_PIECE_COUNT);

  always_comb begin
    for (int i = 0; i < MAX_PIECE_COUNT; i++) begin
      piece_mask[i] = (PIECES_W'(i) < npieces);
    end
  end

  assign last_peer    = ({1'b0, p} == (npeers - PEERS_W'(1)));
  assign usable       = (p == '0) || (p != cfg.my_peer_index);
  assign rd_row       = p[ROW_W-1:0];
  assign acc_now      = acc | (usable ? rd_data : '0);
  assign low_chunk    = cand[CHUNK_W-1:0];
  assign enc          = low_index8(low_chunk);
  assign found_piece  = PIECE_W'(base + PIECE_W'(enc));
  assign row_bit      = rd_data[sel_piece[PIECE_IDX_W-1:0]];
  assign all_done_now = (cfg.my_peer_index == '0) || (&(held | ~piece_mask));

  assign item.ready            = (state == ST_IDLE);
  assign result.valid          = out_valid;
  assign result.request_valid  = out_rq_valid;
  assign result.wanted_piece   = out_rq_piece;
  assign result.request_peer   = out_rq_peer;
  assign result.announce_valid = out_an_valid;
  assign result.announce_piece = out_an_piece;
  assign result.pending        = out_pending;
  assign result.all_done       = out_done;

  always_comb begin
    state_next         = state;
    op_next            = op;
    pidx_next          = pidx;
    piece_in_next      = piece_in;
    ok_next            = ok;
    waiting_flag_next  = waiting_flag;
    waiting_piece_next = waiting_piece;
    waiting_peer_next  = waiting_peer;
    p_next             = p;
    acc_next           = acc;
    cand_next          = cand;
    base_next          = base;
    sel_piece_next     = sel_piece;
    res_rq_valid_next  = res_rq_valid;
    res_rq_piece_next  = res_rq_piece;
    res_rq_peer_next   = res_rq_peer;
    res_an_valid_next  = res_an_valid;
    res_an_piece_next  = res_an_piece;
    out_valid_next     = out_valid;
    out_rq_valid_next  = out_rq_valid;
    out_rq_piece_next  = out_rq_piece;
    out_rq_peer_next   = out_rq_peer;
    out_an_valid_next  = out_an_valid;
    out_an_piece_next  = out_an_piece;
    out_pending_next   = out_pending;
    out_done_next      = out_done;
    cmd                = '0;

    if (out_valid && result.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (item.valid) begin
          op_next           = item.opcode;
          pidx_next         = item.peer_index;
          piece_in_next     = item.piece_index;
          ok_next           = item.reply_ok;
          res_rq_valid_next = 1'b0;
          res_rq_piece_next = '0;
          res_rq_peer_next  = '0;
          res_an_valid_next = 1'b0;
          res_an_piece_next = '0;
          state_next        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_DONE;
        unique case (op)
          OP_HAVE: begin
            if (({1'b0, pidx} < npeers) && ({1'b0, piece_in} < PIECES_W'(MAX_PIECE_COUNT))) begin
              cmd.row_set = 1'b1;
              cmd.row     = pidx;
              cmd.piece   = piece_in;
            end
          end
          OP_REPLY: begin
            if (waiting_flag) begin
              waiting_flag_next  = 1'b0;
              waiting_piece_next = '0;
              waiting_peer_next  = '0;
              cmd.piece          = waiting_piece;
              if (ok) begin
                cmd.held_set      = 1'b1;
                cmd.row_set       = ({1'b0, cfg.my_peer_index} < PEERS_W'(NUM_ROWS));
                cmd.row           = cfg.my_peer_index;
                res_an_valid_next = 1'b1;
                res_an_piece_next = waiting_piece;
              end else begin
                cmd.row_clr = 1'b1;
                cmd.row     = waiting_peer;
              end
            end
          end
          OP_SCHED: begin
            if (!waiting_flag && (cfg.my_peer_index != '0) && (npeers != '0)) begin
              p_next     = '0;
              acc_next   = '0;
              state_next = ST_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        acc_next = acc_now;
        if (last_peer) begin
          cand_next  = PAD_W'(acc_now & ~held & piece_mask);
          base_next  = '0;
          state_next = ST_FIND;
        end else begin
          p_next = p + PEER_W'(1);
        end
      end
      ST_FIND: begin
        if (cand == '0) begin
          state_next = ST_DONE;
        end else if (low_chunk != '0) begin
          sel_piece_next = found_piece;
          if (npeers == PEERS_W'(1)) begin
            waiting_flag_next  = 1'b1;
            waiting_piece_next = found_piece;
            waiting_peer_next  = '0;
            res_rq_valid_next  = 1'b1;
            res_rq_piece_next  = found_piece;
            res_rq_peer_next   = '0;
            state_next         = ST_DONE;
          end else begin
            p_next     = PEER_W'(1);
            state_next = ST_SRC;
          end
        end else begin
          cand_next = cand >> CHUNK_W;
          base_next = PIECE_W'(base + PIECE_W'(CHUNK_W));
        end
      end
      ST_SRC: begin
        if ((p != cfg.my_peer_index) && row_bit) begin
          waiting_flag_next  = 1'b1;
          waiting_piece_next = sel_piece;
          waiting_peer_next  = p;
          res_rq_valid_next  = 1'b1;
          res_rq_piece_next  = sel_piece;
          res_rq_peer_next   = p;
          state_next         = ST_DONE;
        end else if (last_peer) begin
          waiting_flag_next  = 1'b1;
          waiting_piece_next = sel_piece;
          waiting_peer_next  = '0;
          res_rq_valid_next  = 1'b1;
          res_rq_piece_next  = sel_piece;
          res_rq_peer_next   = '0;
          state_next         = ST_DONE;
        end else begin
          p_next = p + PEER_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          out_valid_next    = 1'b1;
          out_rq_valid_next = res_rq_valid;
          out_rq_piece_next = res_rq_piece;
          out_rq_peer_next  = res_rq_peer;
          out_an_valid_next = res_an_valid;
          out_an_piece_next = res_an_piece;
          out_pending_next  = waiting_flag;
          out_done_next     = all_done_now;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      waiting_flag  <= 1'b0;
      waiting_piece <= '0;
      waiting_peer  <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      waiting_flag  <= waiting_flag_next;
      waiting_piece <= waiting_piece_next;
      waiting_peer  <= waiting_peer_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op           <= op_next;
    pidx         <= pidx_next;
    piece_in     <= piece_in_next;
    ok           <= ok_next;
    p            <= p_next;
    acc          <= acc_next;
    cand         <= cand_next;
    base         <= base_next;
    sel_piece    <= sel_piece_next;
    res_rq_valid <= res_rq_valid_next;
    res_rq_piece <= res_rq_piece_next;
    res_rq_peer  <= res_rq_peer_next;
    res_an_valid <= res_an_valid_next;
    res_an_piece <= res_an_piece_next;
    out_rq_valid <= out_rq_valid_next;
    out_rq_piece <= out_rq_piece_next;
    out_rq_peer  <= out_rq_peer_next;
    out_an_valid <= out_an_valid_next;
    out_an_piece <= out_an_piece_next;
    out_pending  <= out_pending_next;
    out_done     <= out_done_next;
  end

endmodule

// File: sv/prs_checker.sv
// Port level checks of the piece request scheduler and their binding to the top level.
module prs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic request_valid,
  input logic announce_valid,
  input logic pending,
  input logic all_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result withdrawn before it was taken.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken again while a request is still being worked on.");

  a_request_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_valid |-> pending && !all_done)
    else $error("Issued request not reported as outstanding.");

  a_announce_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && announce_valid |-> !request_valid && !pending)
    else $error("Announcement given together with an outstanding request.");

endmodule

bind piece_request_scheduler prs_checker u_prs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (item.valid),
  .in_ready      (item.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .request_valid (result.request_valid),
  .announce_valid(result.announce_valid),
  .pending       (result.pending),
  .all_done      (result.all_done)
);
